// ===== design/l1rn_pkg.sv =====
// ----------------------------------------------------------------------------
// l1rn_pkg
// Shared constants and types of the L1-root descriptor normalizer.
// ----------------------------------------------------------------------------
package l1rn_pkg;

  localparam int MaxPairs = 64;
  localparam int ElemBits = 16;
  localparam int FieldBits = 16;
  localparam int AddrBits = (MaxPairs > 1) ? $clog2(MaxPairs) : 1;
  localparam int CountBits = $clog2(MaxPairs + 1);
  localparam int SumBits = 23;
  localparam int QuotBits = ElemBits + 32;  // element * 2^32 / sum
  localparam int RootBits = 24;             // enough for isqrt of 48 bits
  localparam int RootSteps = QuotBits / 2;
  localparam int DivSteps = ElemBits + 32;
  localparam int RootMax = 65535;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_CALC,
    ST_WAIT,
    ST_EMIT
  } state_e;

  // start and busy flags of one lane's divide and root pass
  typedef struct packed {
    logic start;
    logic busy;
  } lane_ctl_t;

endpackage

// ===== design/l1rn_if.sv =====
// ----------------------------------------------------------------------------
// l1rn_in_if / l1rn_out_if
// Valid-ready channels carrying input pairs and result pairs.
// ----------------------------------------------------------------------------
interface l1rn_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value_a;
  logic [15:0] value_b;
  logic        row_end;
  modport source (output valid, value_a, value_b, row_end, input ready);
  modport sink   (input valid, value_a, value_b, row_end, output ready);
endinterface

interface l1rn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] root_a;
  logic [15:0] root_b;
  logic        zero_norm;
  logic        run_end;
  modport source (output valid, root_a, root_b, zero_norm, run_end, input ready);
  modport sink   (input valid, root_a, root_b, zero_norm, run_end, output ready);
endinterface

// ===== design/l1_root_descriptor_normalizer.sv =====
// ----------------------------------------------------------------------------
// l1_root_descriptor_normalizer
// RootSIFT style L1-root normalization of descriptor rows.
// ----------------------------------------------------------------------------
// Usage: requests on in_if carry a pair of unsigned elements and a row_end
// mark. One pair is taken per cycle while loading; pairs are stored in a
// 64-entry row RAM and summed. Pairs beyond 64 in a row are dropped. The
// request marked row_end closes the row; the block then stops taking input
// and emits one result per stored pair on out_if, in arrival order, each
// carrying sqrt(element/sum) in Q0.16 saturated to 65535 for both elements.
// Two lanes (one for each element) each run a 48-step restoring divide and
// a 24-step square root. Each result passes a RAM read, the lane start, the
// lane steps, a wait until both lanes are idle and the output register is
// free, and the load of the output register. A zero-sum row skips the root
// and gives zeros with zero_norm set. While the receiver stalls, a result
// waits in the output register and the next pair is computed meanwhile,
// then held until the register is free. Reset empties the row and returns
// to loading; row RAM content is not cleared, only written entries are
// ever read.
// ----------------------------------------------------------------------------
module l1_root_descriptor_normalizer
  import l1rn_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  l1rn_in_if.sink       in_if,
  l1rn_out_if.source    out_if
);
  state_e               st_q, st_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [CountBits-1:0] idx_q, idx_d;
  logic [SumBits-1:0]   sum_q, sum_d;
  logic                 ovalid_q, ovalid_d;
  logic [15:0]          oa_q, ob_q;
  logic                 oz_q, oend_q;
  logic                 we;
  logic                 lane_go;
  logic [31:0]          rdata;
  logic [ElemBits-1:0]  ea, eb;
  lane_ctl_t            ctl_a, ctl_b;
  logic [15:0]          ra, rb;
  logic                 in_acc;

  assign in_if.ready = (st_q == ST_LOAD);
  assign in_acc      = in_if.valid && in_if.ready;
  assign we          = in_acc && (cnt_q < CountBits'(MaxPairs));
  assign ea          = in_if.value_a[ElemBits-1:0];
  assign eb          = in_if.value_b[ElemBits-1:0];

  l1rn_ram #(.Width(32), .Depth(MaxPairs)) u_row (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AddrBits-1:0]),
    .wdata_i ({16'(eb), 16'(ea)}),
    .raddr_i (idx_q[AddrBits-1:0]),
    .rdata_o (rdata)
  );

  assign lane_go = (st_q == ST_CALC);

  l1rn_lane u_lane_a (
    .clk_i, .rst_ni, .start_i(lane_go), .elem_i(rdata[ElemBits-1:0]),
    .sum_i(sum_q), .ctl_o(ctl_a), .root_o(ra));
  l1rn_lane u_lane_b (
    .clk_i, .rst_ni, .start_i(lane_go), .elem_i(rdata[16+ElemBits-1:16]),
    .sum_i(sum_q), .ctl_o(ctl_b), .root_o(rb));

  // row sequencer and merge of both lanes into one result
  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    ovalid_d = ovalid_q;
    if (out_if.ready) ovalid_d = 1'b0;
    unique case (st_q)
      ST_LOAD: begin
        if (we) begin
          cnt_d = cnt_q + 1'b1;
          sum_d = sum_q + SumBits'(ea) + SumBits'(eb);
        end
        if (in_acc && in_if.row_end) begin
          idx_d = '0;
          st_d  = ((we ? cnt_q + 1'b1 : cnt_q) == '0) ? ST_LOAD : ST_READ;
          if ((we ? cnt_q + 1'b1 : cnt_q) == '0) begin
            cnt_d = '0;
            sum_d = '0;
          end
        end
      end
      ST_READ: st_d = ST_CALC;
      ST_CALC: st_d = ST_WAIT;
      ST_WAIT: begin
        if (!ctl_a.busy && !ctl_b.busy && !ovalid_q) st_d = ST_EMIT;
      end
      ST_EMIT: begin
        ovalid_d = 1'b1;
        idx_d    = idx_q + 1'b1;
        if (idx_q + 1'b1 == cnt_q) begin
          st_d  = ST_LOAD;
          cnt_d = '0;
          sum_d = '0;
        end else begin
          st_d = ST_READ;
        end
      end
      default: st_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_LOAD;
      cnt_q    <= '0;
      idx_q    <= '0;
      sum_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_EMIT) begin
      oa_q   <= (sum_q == '0) ? 16'd0 : ra;
      ob_q   <= (sum_q == '0) ? 16'd0 : rb;
      oz_q   <= (sum_q == '0);
      oend_q <= (idx_q + 1'b1 == cnt_q);
    end
  end

  assign out_if.valid     = ovalid_q;
  assign out_if.root_a    = oa_q;
  assign out_if.root_b    = ob_q;
  assign out_if.zero_norm = oz_q;
  assign out_if.run_end   = oend_q;

  // both lanes run in lockstep
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_a.busy == ctl_b.busy) else $error("lanes out of step");
  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_a.busy |-> !in_if.ready) else $error("input open while computing");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountBits'(MaxPairs)) else $error("pair count overflow");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_EMIT |-> !ovalid_q) else $error("result overwritten");
endmodule

// ===== design/l1rn_ram.sv =====
// ----------------------------------------------------------------------------
// l1rn_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module l1rn_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/l1rn_lane.sv =====
// ----------------------------------------------------------------------------
// l1rn_lane
// One lane: restoring divide of element*2^32 by the sum, then (for a nonzero
// sum) a bit-pair integer square root, one step per cycle, saturated to 16 bits.
// ----------------------------------------------------------------------------
module l1rn_lane
  import l1rn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ElemBits-1:0] elem_i,
  input  logic [SumBits-1:0]  sum_i,
  output lane_ctl_t           ctl_o,
  output logic [15:0]         root_o
);
  typedef enum logic [1:0] {L_IDLE, L_DIV, L_ROOT} lstate_e;

  lstate_e              st_q, st_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [QuotBits-1:0]  num_q, num_d;     // dividend shifting out, quotient in
  logic [SumBits:0]     rem_q, rem_d;
  logic [SumBits-1:0]   div_q;
  logic [QuotBits+1:0]  rr_q, rr_d;       // root remainder
  logic [RootBits-1:0]  res_q, res_d;
  logic [15:0]          root_q, root_d;
  logic [SumBits:0]     trial;
  logic [QuotBits+1:0]  rtrial;
  logic [QuotBits+1:0]  rshift;

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    rr_d   = rr_q;
    res_d  = res_q;
    root_d = root_q;
    trial  = '0;
    rtrial = '0;
    rshift = '0;
    unique case (st_q)
      L_IDLE: begin
        if (start_i) begin
          num_d = {elem_i, 32'd0};
          rem_d = '0;
          cnt_d = 6'(DivSteps - 1);
          st_d  = L_DIV;
        end
      end
      L_DIV: begin
        // one quotient bit per cycle
        trial = {rem_q[SumBits-1:0], num_q[QuotBits-1]};
        if (trial >= {1'b0, div_q}) begin
          rem_d = trial - {1'b0, div_q};
          num_d = {num_q[QuotBits-2:0], 1'b1};
        end else begin
          rem_d = trial;
          num_d = {num_q[QuotBits-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          rr_d  = '0;
          res_d = '0;
          cnt_d = 6'(RootSteps - 1);
          st_d  = (div_q == '0) ? L_IDLE : L_ROOT;
          if (div_q == '0) root_d = '0;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      L_ROOT: begin
        // one root bit per cycle, two radicand bits consumed
        rshift = {rr_q[QuotBits-1:0], num_q[QuotBits-1:QuotBits-2]};
        rtrial = {(QuotBits-RootBits)'(0), res_q, 2'b01};
        if (rshift >= rtrial) begin
          rr_d  = rshift - rtrial;
          res_d = {res_q[RootBits-2:0], 1'b1};
        end else begin
          rr_d  = rshift;
          res_d = {res_q[RootBits-2:0], 1'b0};
        end
        num_d = {num_q[QuotBits-3:0], 2'b00};
        if (cnt_q == '0) begin
          root_d = (res_d > RootBits'(RootMax)) ? 16'(RootMax) : res_d[15:0];
          st_d   = L_IDLE;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      default: st_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= L_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    rr_q   <= rr_d;
    res_q  <= res_d;
    root_q <= root_d;
    if (start_i && st_q == L_IDLE) div_q <= sum_i;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = (st_q != L_IDLE);
  assign root_o      = root_q;
endmodule

// ===== tb/tb_l1_root_descriptor_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_l1_root_descriptor_normalizer
// Sends descriptor rows as requests and checks each result pair against
// expected roots. The expected values come from an exact integer divide and
// square root kept in this file. A directed table comes first, then a full
// row, an overflow row and random rows. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module tb_l1_root_descriptor_normalizer;
  import l1rn_pkg::*;

  typedef struct packed {
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic        row_end;
  } pair_req_t;

  typedef struct packed {
    logic [15:0] root_a;
    logic [15:0] root_b;
    logic        zero_norm;
    logic        run_end;
  } root_res_t;

  // directed request, with its expected result where it is obvious
  typedef struct packed {
    pair_req_t  req;
    logic       typed;
    root_res_t  res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  l1rn_in_if  in_if ();
  l1rn_out_if out_if ();

  l1_root_descriptor_normalizer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0]    row_pairs [MaxPairs];
  logic [SumBits-1:0] row_sum;
  int             row_count;
  root_res_t      pending_roots [$];
  root_res_t      typed_roots [$];
  logic           typed_flags [$];
  int             fail_count = 0;
  int             idle_pct = 36;

  function automatic logic [15:0] root_of_share(logic [15:0] elem,
                                                logic [SumBits-1:0] sum);
    logic [63:0] quot;
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    if (sum == 0) return 16'd0;
    quot = ({48'd0, elem} << 32) / 64'(sum);
    rem = quot;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (res > 64'(RootMax)) res = 64'(RootMax);
    return res[15:0];
  endfunction

  // model one accepted request
  task automatic predict_row(pair_req_t r, logic typed, root_res_t tres);
    root_res_t e;
    if (row_count < MaxPairs) begin
      row_pairs[row_count] = {r.value_b, r.value_a};
      row_sum = row_sum + SumBits'(r.value_a) + SumBits'(r.value_b);
      row_count++;
    end
    if (r.row_end) begin
      for (int k = 0; k < row_count; k++) begin
        e.root_a = root_of_share(row_pairs[k][15:0], row_sum);
        e.root_b = root_of_share(row_pairs[k][31:16], row_sum);
        e.zero_norm = (row_sum == 0);
        e.run_end = (k + 1 == row_count);
        pending_roots.push_back(e);
        typed_flags.push_back(typed && k + 1 == row_count);
        typed_roots.push_back(tres);
      end
      row_sum = '0;
      row_count = 0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    root_res_t e;
    root_res_t t;
    logic tf;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = pending_roots.pop_front();
        t = typed_roots.pop_front();
        tf = typed_flags.pop_front();
        if (tf && t != e) report_mismatch("typed row vs predictor", int'(t), int'(e));
        if (out_if.root_a !== e.root_a)
          report_mismatch("root_a", int'(out_if.root_a), int'(e.root_a));
        if (out_if.root_b !== e.root_b)
          report_mismatch("root_b", int'(out_if.root_b), int'(e.root_b));
        if (out_if.zero_norm !== e.zero_norm)
          report_mismatch("zero_norm", int'(out_if.zero_norm), int'(e.zero_norm));
        if (out_if.run_end !== e.run_end)
          report_mismatch("run_end", int'(out_if.run_end), int'(e.run_end));
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // valid stays high between back-to-back requests; the caller drops it
  task automatic send_pair(pair_req_t r, logic typed, root_res_t tres);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value_a <= r.value_a;
    in_if.value_b <= r.value_b;
    in_if.row_end <= r.row_end;
    do @(posedge clk_i); while (!in_if.ready);
    predict_row(r, typed, tres);
  endtask

  function automatic pair_req_t rand_pair(logic last);
    pair_req_t r;
    int m;
    m = $urandom_range(3);
    r.value_a = (m == 0) ? 16'($urandom_range(15)) : 16'($urandom);
    r.value_b = (m == 1) ? 16'hFFFF : 16'($urandom);
    r.row_end = last;
    return r;
  endfunction

  dir_row_t dir_table [] = '{
    // single pair, a alone carries the sum: 1.0 saturates, b is zero
    '{'{16'hFFFF, 16'h0000, 1'b1}, 1'b1, '{16'hFFFF, 16'h0000, 1'b0, 1'b1}},
    // zero sum row
    '{'{16'h0000, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 1'b1}, 1'b1, '{16'h0000, 16'h0000, 1'b1, 1'b1}},
    // equal halves: sqrt(1/2)
    '{'{16'h0001, 16'h0001, 1'b1}, 1'b1, '{16'd46340, 16'd46340, 1'b0, 1'b1}},
    // b carries all
    '{'{16'h0000, 16'h8000, 1'b1}, 1'b1, '{16'h0000, 16'hFFFF, 1'b0, 1'b1}},
    // small and large mixes
    '{'{16'hFFFF, 16'h0001, 1'b0}, 1'b0, '0},
    '{'{16'h0001, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{16'hAAAA, 16'h5555, 1'b1}, 1'b0, '0},
    '{'{16'h5555, 16'hAAAA, 1'b0}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, '0}
  };

  initial begin
    pair_req_t r;
    int n;
    int sent;
    row_sum = '0;
    row_count = 0;
    in_if.valid = 1'b0;
    in_if.value_a = '0;
    in_if.value_b = '0;
    in_if.row_end = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) send_pair(dir_table[i].req, dir_table[i].typed, dir_table[i].res);

    // full row of maximum values, then overflow row with the end dropped
    for (int k = 0; k < MaxPairs; k++)
      send_pair('{16'hFFFF, 16'hFFFF, k == MaxPairs-1}, 1'b0, '0);
    for (int k = 0; k < MaxPairs + 3; k++) send_pair(rand_pair(k == MaxPairs + 2), 1'b0, '0);
    sent = 11 + 2 * MaxPairs + 3;
    in_if.valid <= 1'b0;

    // hold off until all results are back
    while (pending_roots.size() != 0) @(posedge clk_i);

    // random rows, mostly short
    while (sent < 310) begin
      idle_pct = ((sent / 60) % 3 == 1) ? 0 : 36;
      n = ($urandom_range(9) == 0) ? $urandom_range(MaxPairs + 2, 1) : $urandom_range(6, 1);
      for (int k = 0; k < n; k++) begin
        r = rand_pair(k == n - 1);
        if ($urandom_range(15) == 0) begin
          r.value_a = '0;
          r.value_b = '0;
        end
        send_pair(r, 1'b0, '0);
        sent++;
      end
    end
    in_if.valid <= 1'b0;
    idle_pct = 36;

    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_l1_root_descriptor_normalizer: PASS");
    end else begin
      $display("tb_l1_root_descriptor_normalizer: FAIL");
    end
    $finish;
  end

  // watchdog: ~310 results plus stalls, with a wide margin
  initial begin
    #20ms;
    $display("tb_l1_root_descriptor_normalizer: FAIL");
    $finish;
  end

endmodule
